FILE: sv/ltgf_pkg.sv
package ltgf_pkg;

  // Default sizes, handed to the top level parameters.
  localparam int MAX_WIDTH_DEF = 64;
  localparam int MAX_DEPTH_DEF = 64;
  localparam int MAX_LINKS_DEF = 8;

  // Request opcodes.
  localparam logic [1:0] OP_LOAD  = 2'd0;
  localparam logic [1:0] OP_LINK  = 2'd1;
  localparam logic [1:0] OP_BUILD = 2'd2;
  localparam logic [1:0] OP_READ  = 2'd3;

  // Result status codes.
  localparam logic [1:0] STS_OK       = 2'd0;
  localparam logic [1:0] STS_OFF_GRID = 2'd1;
  localparam logic [1:0] STS_DOOR_BAD = 2'd2;
  localparam logic [1:0] STS_FULL     = 2'd3;

  // Configuration register indexes.
  localparam logic [1:0] REG_GRID_WIDTH = 2'd0;
  localparam logic [1:0] REG_GRID_DEPTH = 2'd1;
  localparam logic [1:0] REG_STEP_TOL   = 2'd2;
  localparam logic [1:0] REG_USE_JUMPS  = 2'd3;

  // Route codes and costs.
  localparam logic [3:0]  CODE_JUMP = 4'd8;
  localparam logic [3:0]  CODE_DOOR = 4'd9;
  localparam logic [3:0]  CODE_NONE = 4'd10;
  localparam logic [15:0] COST_NONE = 16'hFFFF;
  localparam logic [16:0] JUMP_COST = 17'd3;
  localparam logic signed [15:0] UPPER_DOOR_LEVEL = 16'sd384;

  // Datapath commands issued by the controller.
  typedef enum logic [4:0] {
    C_NOP, C_LATCH, C_CLR, C_BCLR, C_LOAD, C_LINK, C_READ_RD, C_READ_OUT,
    C_LV_RD, C_LV_A, C_LV_B, C_LV_C, C_DOOR_RD, C_DOOR, C_FIN_OK,
    C_POP_RD, C_POP, C_NODE, C_CARD_RD, C_JRD, C_JLK, C_EVAL, C_ADV
  } cmd_t;

  // Datapath status seen by the controller.
  typedef struct packed {
    logic [1:0] opc;
    logic       sweep_last;
    logic       lv_more;
    logic       door_fail;
    logic       q_empty;
    logic       in_card;
    logic       card_ok;
    logic       jump_end;
    logic       jump_try;
    logic       jmatch;
  } stat_t;

endpackage

FILE: sv/ltgf_ctrl.sv
module ltgf_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  ltgf_pkg::stat_t   st,
  output ltgf_pkg::cmd_t    cmd,
  output logic              busy
);

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_DISP, S_READ, S_BCLR, S_LV, S_LVA, S_LVB, S_LVC,
    S_DOOR, S_POP0, S_POP1, S_NODE, S_CRD, S_JLK, S_CEV
  } state_t;

  state_t state_r, state_nxt;
  logic   busy_r;

  // Next state and command for the datapath.
  always_comb begin
    state_nxt = state_r;
    cmd       = ltgf_pkg::C_NOP;
    case (state_r)
      S_CLR: begin
        cmd = ltgf_pkg::C_CLR;
        if (st.sweep_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          cmd       = ltgf_pkg::C_LATCH;
          state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        case (st.opc)
          ltgf_pkg::OP_LOAD: begin
            cmd       = ltgf_pkg::C_LOAD;
            state_nxt = S_IDLE;
          end
          ltgf_pkg::OP_LINK: begin
            cmd       = ltgf_pkg::C_LINK;
            state_nxt = S_IDLE;
          end
          ltgf_pkg::OP_READ: begin
            cmd       = ltgf_pkg::C_READ_RD;
            state_nxt = S_READ;
          end
          default: state_nxt = S_BCLR;
        endcase
      end
      S_READ: begin
        cmd       = ltgf_pkg::C_READ_OUT;
        state_nxt = S_IDLE;
      end
      S_BCLR: begin
        cmd = ltgf_pkg::C_BCLR;
        if (st.sweep_last) state_nxt = S_LV;
      end
      S_LV: begin
        if (st.lv_more) begin
          cmd       = ltgf_pkg::C_LV_RD;
          state_nxt = S_LVA;
        end else begin
          cmd       = ltgf_pkg::C_DOOR_RD;
          state_nxt = S_DOOR;
        end
      end
      S_LVA: begin
        cmd       = ltgf_pkg::C_LV_A;
        state_nxt = S_LVB;
      end
      S_LVB: begin
        cmd       = ltgf_pkg::C_LV_B;
        state_nxt = S_LVC;
      end
      S_LVC: begin
        cmd       = ltgf_pkg::C_LV_C;
        state_nxt = S_LV;
      end
      S_DOOR: begin
        cmd       = ltgf_pkg::C_DOOR;
        state_nxt = st.door_fail ? S_IDLE : S_POP0;
      end
      S_POP0: begin
        if (st.q_empty) begin
          cmd       = ltgf_pkg::C_FIN_OK;
          state_nxt = S_IDLE;
        end else begin
          cmd       = ltgf_pkg::C_POP_RD;
          state_nxt = S_POP1;
        end
      end
      S_POP1: begin
        cmd       = ltgf_pkg::C_POP;
        state_nxt = S_NODE;
      end
      S_NODE: begin
        cmd       = ltgf_pkg::C_NODE;
        state_nxt = S_CRD;
      end
      S_CRD: begin
        if (st.in_card) begin
          if (st.card_ok) begin
            cmd       = ltgf_pkg::C_CARD_RD;
            state_nxt = S_CEV;
          end else begin
            cmd = ltgf_pkg::C_ADV;
          end
        end else if (st.jump_end) begin
          state_nxt = S_POP0;
        end else if (st.jump_try) begin
          cmd       = ltgf_pkg::C_JRD;
          state_nxt = S_JLK;
        end else begin
          cmd = ltgf_pkg::C_ADV;
        end
      end
      S_JLK: begin
        cmd       = ltgf_pkg::C_JLK;
        state_nxt = st.jmatch ? S_CEV : S_CRD;
      end
      S_CEV: begin
        cmd       = ltgf_pkg::C_EVAL;
        state_nxt = S_CRD;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // State and busy flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
      busy_r  <= 1'b1;
    end else begin
      state_r <= state_nxt;
      busy_r  <= (state_nxt != S_IDLE);
    end
  end

  assign busy = busy_r;

endmodule

FILE: sv/ltgf_dp.sv
module ltgf_dp #(
  parameter int MAX_WIDTH = ltgf_pkg::MAX_WIDTH_DEF,
  parameter int MAX_DEPTH = ltgf_pkg::MAX_DEPTH_DEF,
  parameter int MAX_LINKS = ltgf_pkg::MAX_LINKS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  ltgf_pkg::cmd_t     cmd,
  output ltgf_pkg::stat_t    st,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [14:0]        cfg_data,
  input  logic [1:0]         in_opcode,
  input  logic [5:0]         in_cell_x,
  input  logic [5:0]         in_cell_z,
  input  logic               in_layer,
  input  logic               in_walkable,
  input  logic signed [15:0] in_height,
  input  logic [5:0]         in_second_x,
  input  logic [5:0]         in_second_z,
  output logic               out_valid,
  output logic [1:0]         out_status,
  output logic [3:0]         out_route_code,
  output logic [15:0]        out_distance
);

  localparam int XB = $clog2(MAX_WIDTH);
  localparam int ZB = $clog2(MAX_DEPTH);
  localparam int NB = XB + ZB + 1;
  localparam int NN = 2 ** NB;
  localparam int LB = (MAX_LINKS > 1) ? $clog2(MAX_LINKS) : 1;
  localparam int KB = $clog2(MAX_LINKS + 1);
  localparam logic [8:0]  MW9 = 9'(MAX_WIDTH);
  localparam logic [8:0]  MD9 = 9'(MAX_DEPTH);
  localparam logic [KB-1:0] ML = KB'(MAX_LINKS);
  localparam logic [20:0] REC_RESET = {ltgf_pkg::CODE_NONE, ltgf_pkg::COST_NONE, 1'b0};

  function automatic logic [NB-1:0] node_addr(logic [8:0] x, logic [8:0] z, logic s);
    return {s, z[ZB-1:0], x[XB-1:0]};
  endfunction

  // Configuration registers.
  logic [6:0]  grid_width_r, grid_depth_r;
  logic [14:0] step_tol_r;
  logic        use_jumps_r;

  // Latched request.
  logic [1:0]         it_op_r, it_op_nxt;
  logic [5:0]         it_x_r, it_x_nxt, it_z_r, it_z_nxt, it_x2_r, it_x2_nxt;
  logic [5:0]         it_z2_r, it_z2_nxt;
  logic               it_layer_r, it_layer_nxt, it_walk_r, it_walk_nxt;
  logic signed [15:0] it_h_r, it_h_nxt;

  // Sequencing registers.
  logic [NB-1:0]        sw_r, sw_nxt, head_r, head_nxt, node_r, node_nxt;
  logic [NB-1:0]        cand_r, cand_nxt;
  logic [NB:0]          cnt_r, cnt_nxt;
  logic [KB-1:0]        k_r, k_nxt, total_r, total_nxt;
  logic [3:0]           ci_r, ci_nxt;
  logic [15:0]          h_r, h_nxt, cost_r, cost_nxt;
  logic                 lipok_r, lipok_nxt, wa_r, wa_nxt;
  logic [MAX_LINKS-1:0] valid_r, valid_nxt;

  // Result registers.
  logic        out_valid_r, out_valid_nxt;
  logic [1:0]  out_status_r, out_status_nxt;
  logic [3:0]  out_code_r, out_code_nxt;
  logic [15:0] out_dist_r, out_dist_nxt;

  // Memories: node geometry {walk, height}, route record {code, cost, queued},
  // work ring of node numbers, and jump link lips.
  logic [16:0]   geo_mem [NN];
  logic [20:0]   rec_mem [NN];
  logic [NB-1:0] ring_mem [NN];
  logic [23:0]   link_mem [MAX_LINKS];
  logic [16:0]   geo_q, geo_wd;
  logic [20:0]   rec_q, rec_wd;
  logic [NB-1:0] ring_q, ring_wd, geo_wa, geo_ra, rec_wa, rec_ra;
  logic [23:0]   link_q;
  logic          geo_we, rec_we, ring_we, link_we;

  // Derived values.
  logic [8:0]    w_eff, d_eff, x9, z9, x29, z29, cx9, cz9, nx9, nz9;
  logic [8:0]    lx1, lz1, lx2, lz2;
  logic          it_on, it2_on, lip_on, door_s, card_ok, upper, k_lt, valid_k;
  logic          jmatch, relax, is_jump;
  logic [NB-1:0] item_addr, door_addr, lipa_addr, lipb_addr, card_addr, other, tail;
  logic [1:0]    dir_i;
  logic [3:0]    card_code;
  logic [16:0]   nd, jd, diff, absd, cand_cost;

  assign w_eff = ({2'b0, grid_width_r} > MW9) ? MW9 : {2'b0, grid_width_r};
  assign d_eff = ({2'b0, grid_depth_r} > MD9) ? MD9 : {2'b0, grid_depth_r};
  assign x9  = {3'b0, it_x_r};
  assign z9  = {3'b0, it_z_r};
  assign x29 = {3'b0, it_x2_r};
  assign z29 = {3'b0, it_z2_r};
  assign it_on  = (x9 < w_eff) && (z9 < d_eff);
  assign it2_on = (x29 < w_eff) && (z29 < d_eff);
  assign door_s = (it_h_r > ltgf_pkg::UPPER_DOOR_LEVEL);
  assign item_addr = node_addr(x9, z9, it_layer_r);
  assign door_addr = node_addr(x9, z9, door_s);

  // Link lips of the entry at the link counter.
  assign lx1 = {3'b0, link_q[23:18]};
  assign lz1 = {3'b0, link_q[17:12]};
  assign lx2 = {3'b0, link_q[11:6]};
  assign lz2 = {3'b0, link_q[5:0]};
  assign lip_on = (lx1 < w_eff) && (lz1 < d_eff) && (lx2 < w_eff) && (lz2 < d_eff);
  assign lipa_addr = node_addr(lx1, lz1, 1'b1);
  assign lipb_addr = node_addr(lx2, lz2, 1'b1);
  assign jmatch = (node_r == lipa_addr) || (node_r == lipb_addr);
  assign other  = (node_r == lipa_addr) ? lipb_addr : lipa_addr;

  // Cardinal neighbor of the current node for candidate index ci_r.
  assign cx9   = 9'(node_r[XB-1:0]);
  assign cz9   = 9'(node_r[XB+ZB-1:XB]);
  assign dir_i = ci_r[2:1];
  assign card_code = {1'b0, 2'(dir_i + 2'd2), 1'b0};
  always_comb begin
    nx9 = cx9;
    nz9 = cz9;
    card_ok = 1'b0;
    case (dir_i)
      2'd0: begin
        nx9 = cx9 + 9'd1;
        card_ok = (nx9 < w_eff);
      end
      2'd1: begin
        nz9 = cz9 + 9'd1;
        card_ok = (nz9 < d_eff);
      end
      2'd2: begin
        nx9 = cx9 - 9'd1;
        card_ok = (cx9 != 9'd0);
      end
      default: begin
        nz9 = cz9 - 9'd1;
        card_ok = (cz9 != 9'd0);
      end
    endcase
  end
  assign card_addr = node_addr(nx9, nz9, ci_r[0]);

  assign upper   = node_r[NB-1];
  assign k_lt    = (k_r < total_r);
  assign valid_k = valid_r[k_r[LB-1:0]];
  assign is_jump = ci_r[3];
  assign tail    = head_r + cnt_r[NB-1:0];

  // Relaxation test of the candidate node.
  assign nd   = {1'b0, cost_r} + 17'd1;
  assign jd   = {1'b0, cost_r} + ltgf_pkg::JUMP_COST;
  assign diff = {h_r[15], h_r} - {geo_q[15], geo_q[15:0]};
  assign absd = diff[16] ? (~diff + 17'd1) : diff;
  assign cand_cost = {1'b0, rec_q[16:1]};
  assign relax = is_jump ? (jd < cand_cost)
               : (geo_q[16] && (absd <= {2'b0, step_tol_r}) && (nd < cand_cost));

  // Status to the controller.
  assign st.opc        = it_op_r;
  assign st.sweep_last = &sw_r;
  assign st.lv_more    = use_jumps_r && k_lt;
  assign st.door_fail  = !it_on || !geo_q[16];
  assign st.q_empty    = (cnt_r == '0);
  assign st.in_card    = !ci_r[3];
  assign st.card_ok    = card_ok;
  assign st.jump_end   = ci_r[3] && (!upper || !k_lt);
  assign st.jump_try   = ci_r[3] && upper && k_lt && valid_k;
  assign st.jmatch     = jmatch;

  // Command decode.
  always_comb begin
    it_op_nxt = it_op_r;   it_x_nxt = it_x_r;     it_z_nxt = it_z_r;
    it_x2_nxt = it_x2_r;   it_z2_nxt = it_z2_r;   it_layer_nxt = it_layer_r;
    it_walk_nxt = it_walk_r; it_h_nxt = it_h_r;
    sw_nxt = sw_r;   head_nxt = head_r;   node_nxt = node_r;   cand_nxt = cand_r;
    cnt_nxt = cnt_r; k_nxt = k_r;         total_nxt = total_r; ci_nxt = ci_r;
    h_nxt = h_r;     cost_nxt = cost_r;   lipok_nxt = lipok_r; wa_nxt = wa_r;
    valid_nxt = valid_r;
    out_valid_nxt = 1'b0;
    out_status_nxt = out_status_r;
    out_code_nxt = out_code_r;
    out_dist_nxt = out_dist_r;
    geo_we = 1'b0;  geo_wa = item_addr; geo_wd = {it_walk_r, it_h_r}; geo_ra = card_addr;
    rec_we = 1'b0;  rec_wa = cand_r;    rec_wd = REC_RESET;           rec_ra = card_addr;
    ring_we = 1'b0; ring_wd = cand_r;
    link_we = 1'b0;
    case (cmd)
      ltgf_pkg::C_LATCH: begin
        it_op_nxt = in_opcode;   it_x_nxt = in_cell_x;   it_z_nxt = in_cell_z;
        it_x2_nxt = in_second_x; it_z2_nxt = in_second_z; it_layer_nxt = in_layer;
        it_walk_nxt = in_walkable; it_h_nxt = in_height;
        sw_nxt = '0; k_nxt = '0; ci_nxt = '0; head_nxt = '0; cnt_nxt = '0;
        valid_nxt = '0;
      end
      ltgf_pkg::C_CLR: begin
        geo_we = 1'b1; geo_wa = sw_r; geo_wd = '0;
        rec_we = 1'b1; rec_wa = sw_r;
        sw_nxt = sw_r + 1'b1;
      end
      ltgf_pkg::C_BCLR: begin
        rec_we = 1'b1; rec_wa = sw_r;
        sw_nxt = sw_r + 1'b1;
      end
      ltgf_pkg::C_LOAD: begin
        out_valid_nxt = 1'b1; out_code_nxt = '0; out_dist_nxt = '0;
        out_status_nxt = it_on ? ltgf_pkg::STS_OK : ltgf_pkg::STS_OFF_GRID;
        geo_we = it_on;
      end
      ltgf_pkg::C_LINK: begin
        out_valid_nxt = 1'b1; out_code_nxt = '0; out_dist_nxt = '0;
        if (!(it_on && it2_on)) begin
          out_status_nxt = ltgf_pkg::STS_OFF_GRID;
        end else if (total_r >= ML) begin
          out_status_nxt = ltgf_pkg::STS_FULL;
        end else begin
          out_status_nxt = ltgf_pkg::STS_OK;
          link_we = 1'b1;
          total_nxt = total_r + 1'b1;
        end
      end
      ltgf_pkg::C_READ_RD: rec_ra = item_addr;
      ltgf_pkg::C_READ_OUT: begin
        out_valid_nxt = 1'b1;
        if (it_on) begin
          out_status_nxt = ltgf_pkg::STS_OK;
          out_code_nxt = rec_q[20:17];
          out_dist_nxt = rec_q[16:1];
        end else begin
          out_status_nxt = ltgf_pkg::STS_OFF_GRID;
          out_code_nxt = ltgf_pkg::CODE_NONE;
          out_dist_nxt = ltgf_pkg::COST_NONE;
        end
      end
      ltgf_pkg::C_LV_A: begin
        geo_ra = lipa_addr;
        lipok_nxt = lip_on;
      end
      ltgf_pkg::C_LV_B: begin
        geo_ra = lipb_addr;
        wa_nxt = geo_q[16];
      end
      ltgf_pkg::C_LV_C: begin
        valid_nxt[k_r[LB-1:0]] = lipok_r && wa_r && geo_q[16];
        k_nxt = k_r + 1'b1;
      end
      ltgf_pkg::C_DOOR_RD: geo_ra = door_addr;
      ltgf_pkg::C_DOOR: begin
        out_code_nxt = '0; out_dist_nxt = '0;
        if (!it_on) begin
          out_valid_nxt = 1'b1;
          out_status_nxt = ltgf_pkg::STS_OFF_GRID;
        end else if (!geo_q[16]) begin
          out_valid_nxt = 1'b1;
          out_status_nxt = ltgf_pkg::STS_DOOR_BAD;
        end else begin
          rec_we = 1'b1; rec_wa = door_addr;
          rec_wd = {ltgf_pkg::CODE_DOOR, 16'd0, 1'b1};
          ring_we = 1'b1; ring_wd = door_addr;
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ltgf_pkg::C_FIN_OK: begin
        out_valid_nxt = 1'b1; out_status_nxt = ltgf_pkg::STS_OK;
        out_code_nxt = '0; out_dist_nxt = '0;
      end
      ltgf_pkg::C_POP: begin
        node_nxt = ring_q;
        geo_ra = ring_q; rec_ra = ring_q;
        head_nxt = head_r + 1'b1;
        cnt_nxt = cnt_r - 1'b1;
      end
      ltgf_pkg::C_NODE: begin
        h_nxt = geo_q[15:0];
        cost_nxt = rec_q[16:1];
        rec_we = 1'b1; rec_wa = node_r; rec_wd = {rec_q[20:1], 1'b0};
        ci_nxt = '0; k_nxt = '0;
      end
      ltgf_pkg::C_CARD_RD: cand_nxt = card_addr;
      ltgf_pkg::C_JLK: begin
        if (jmatch) begin
          rec_ra = other;
          cand_nxt = other;
        end else begin
          k_nxt = k_r + 1'b1;
        end
      end
      ltgf_pkg::C_EVAL: begin
        if (relax) begin
          rec_we = 1'b1; rec_wa = cand_r;
          rec_wd = is_jump ? {ltgf_pkg::CODE_JUMP, jd[15:0], 1'b1}
                           : {card_code, nd[15:0], 1'b1};
          if (!rec_q[0]) begin
            ring_we = 1'b1;
            cnt_nxt = cnt_r + 1'b1;
          end
        end
        if (is_jump) k_nxt = k_r + 1'b1;
        else ci_nxt = ci_r + 1'b1;
      end
      ltgf_pkg::C_ADV: begin
        if (is_jump) k_nxt = k_r + 1'b1;
        else ci_nxt = ci_r + 1'b1;
      end
      default: ;
    endcase
  end

  // Geometry memory.
  always_ff @(posedge clk) begin
    if (geo_we) geo_mem[geo_wa] <= geo_wd;
    geo_q <= geo_mem[geo_ra];
  end

  // Route record memory.
  always_ff @(posedge clk) begin
    if (rec_we) rec_mem[rec_wa] <= rec_wd;
    rec_q <= rec_mem[rec_ra];
  end

  // Work ring.
  always_ff @(posedge clk) begin
    if (ring_we) ring_mem[tail] <= ring_wd;
    ring_q <= ring_mem[head_r];
  end

  // Jump link store.
  always_ff @(posedge clk) begin
    if (link_we) link_mem[total_r[LB-1:0]] <= {it_x_r, it_z_r, it_x2_r, it_z2_r};
    link_q <= link_mem[k_r[LB-1:0]];
  end

  // Control and configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_width_r <= 7'd64;
      grid_depth_r <= 7'd64;
      step_tol_r   <= 15'd128;
      use_jumps_r  <= 1'b1;
      sw_r         <= '0;
      head_r       <= '0;
      cnt_r        <= '0;
      k_r          <= '0;
      total_r      <= '0;
      ci_r         <= '0;
      valid_r      <= '0;
      out_valid_r  <= 1'b0;
      it_op_r      <= ltgf_pkg::OP_LOAD;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          ltgf_pkg::REG_GRID_WIDTH: grid_width_r <= cfg_data[6:0];
          ltgf_pkg::REG_GRID_DEPTH: grid_depth_r <= cfg_data[6:0];
          ltgf_pkg::REG_STEP_TOL:   step_tol_r   <= cfg_data;
          ltgf_pkg::REG_USE_JUMPS:  use_jumps_r  <= cfg_data[0];
          default: ;
        endcase
      end
      sw_r        <= sw_nxt;
      head_r      <= head_nxt;
      cnt_r       <= cnt_nxt;
      k_r         <= k_nxt;
      total_r     <= total_nxt;
      ci_r        <= ci_nxt;
      valid_r     <= valid_nxt;
      out_valid_r <= out_valid_nxt;
      it_op_r     <= it_op_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    it_x_r <= it_x_nxt;     it_z_r <= it_z_nxt;     it_x2_r <= it_x2_nxt;
    it_z2_r <= it_z2_nxt;   it_layer_r <= it_layer_nxt;
    it_walk_r <= it_walk_nxt; it_h_r <= it_h_nxt;
    node_r <= node_nxt;     cand_r <= cand_nxt;
    h_r <= h_nxt;           cost_r <= cost_nxt;
    lipok_r <= lipok_nxt;   wa_r <= wa_nxt;
    out_status_r <= out_status_nxt;
    out_code_r <= out_code_nxt;
    out_dist_r <= out_dist_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_route_code = out_code_r;
  assign out_distance   = out_dist_r;

endmodule

FILE: sv/two_layer_grid_flow_field_core.sv
// Channel   Direction  Handshake                   Payload
// request   in         start && !busy at the edge  in_opcode .. in_second_z
// result    out        out_valid, one cycle        out_status, out_route_code, out_distance
// config    in         cfg_we at the edge          cfg_index, cfg_data
//
// Load and link requests pass through the latch and dispatch states, reads also through a
// record read state, before the next acceptance. A build clears all 2^NB route records,
// reads the lips of each stored link when jump links are on, checks the door and then,
// per dequeued node, pops it, tries each neighbor slot and each stored link on the upper
// story and closes the node. Each memory gives one registered read a cycle.
// After reset a clearing pass over all 2^NB node addresses wipes the node memories while
// busy stays high. The result receiver cannot stall.
module two_layer_grid_flow_field_core #(
  parameter int MAX_WIDTH = ltgf_pkg::MAX_WIDTH_DEF,
  parameter int MAX_DEPTH = ltgf_pkg::MAX_DEPTH_DEF,
  parameter int MAX_LINKS = ltgf_pkg::MAX_LINKS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         in_opcode,
  input  logic [5:0]         in_cell_x,
  input  logic [5:0]         in_cell_z,
  input  logic               in_layer,
  input  logic               in_walkable,
  input  logic signed [15:0] in_height,
  input  logic [5:0]         in_second_x,
  input  logic [5:0]         in_second_z,
  output logic               out_valid,
  output logic [1:0]         out_status,
  output logic [3:0]         out_route_code,
  output logic [15:0]        out_distance,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [14:0]        cfg_data
);

  ltgf_pkg::cmd_t  cmd;
  ltgf_pkg::stat_t st;

  // Sequencer.
  ltgf_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .st    (st),
    .cmd   (cmd),
    .busy  (busy)
  );

  // Memories, registers and arithmetic.
  ltgf_dp #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_DEPTH (MAX_DEPTH),
    .MAX_LINKS (MAX_LINKS)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .st             (st),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_opcode      (in_opcode),
    .in_cell_x      (in_cell_x),
    .in_cell_z      (in_cell_z),
    .in_layer       (in_layer),
    .in_walkable    (in_walkable),
    .in_height      (in_height),
    .in_second_x    (in_second_x),
    .in_second_z    (in_second_z),
    .out_valid      (out_valid),
    .out_status     (out_status),
    .out_route_code (out_route_code),
    .out_distance   (out_distance)
  );

  // An accepted request keeps the block busy in the next cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy) else $error("busy low after accepted request");

  // Each result lasts one cycle and is never followed directly by another.
  a_single_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("back to back results");

  // A result only follows a cycle in which the block was busy.
  a_result_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy)) else $error("result without work");

endmodule
